>>> hw/rtl/mftt_pkg.sv
package mftt_pkg;

    localparam int MOTOR_COUNT     = 23;
    localparam int COUNTS_PER_TURN = 8192;

    localparam int ID_W    = 11;
    localparam int SLOT_W  = 5;
    localparam int ANGLE_W = 13;
    localparam int TURN_W  = 16;
    localparam int ERR_W   = 31;
    localparam int RAW_W   = 16;
    localparam int TEMP_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam int ABS_FIRST_SLOT     = 8;
    localparam int ABS_SLOTS          = 7;
    localparam int GROUP_B_FIRST_SLOT = 15;
    localparam int GROUP_SLOTS        = 8;

    // item codes
    localparam logic OP_FEEDBACK = 1'b0;
    localparam logic OP_TARGET   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ABS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GROUP_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GROUP_B = 2'd2;

    localparam logic [ID_W-1:0] RST_BASE_ABS     = 11'd517;
    localparam logic [ID_W-1:0] RST_BASE_GROUP_A = 11'd513;
    localparam logic [ID_W-1:0] RST_BASE_GROUP_B = 11'd513;

    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic turn_en;   // update turn count and write back the slot
        logic out_load;  // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic fb_hit;    // feedback beat whose ID maps to a slot
    } t_dp_stat;

endpackage

>>> hw/rtl/motor_feedback_turn_tracker_unit.sv
// Feedback beat: taken in S_IDLE, turn update and write-back in S_TURN, error and correction
// in S_ERR, which loads the result once the output is not stalled. Input stalls outside S_IDLE,
// so a new beat waits until the last result loads. Set-target beats and unmapped IDs stay in S_IDLE.
// Reset (synchronous, active low) clears the slot table and loads the base IDs.
module motor_feedback_turn_tracker_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic [mftt_pkg::ID_W-1:0]             i_frame_id,
    input  logic [mftt_pkg::ANGLE_W-1:0]          i_encoder_raw,
    input  logic signed [mftt_pkg::RAW_W-1:0]     i_speed_raw,
    input  logic signed [mftt_pkg::RAW_W-1:0]     i_current_raw,
    input  logic [mftt_pkg::TEMP_W-1:0]           i_temperature_raw,
    input  logic [mftt_pkg::SLOT_W-1:0]           i_target_slot,
    input  logic [mftt_pkg::ANGLE_W-1:0]          i_target_counts,
    input  logic signed [mftt_pkg::TURN_W-1:0]    i_target_turns,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [mftt_pkg::SLOT_W-1:0]           o_slot,
    output logic [mftt_pkg::ANGLE_W-1:0]          o_angle_counts,
    output logic signed [mftt_pkg::TURN_W-1:0]    o_turn_count,
    output logic signed [mftt_pkg::ERR_W-1:0]     o_angle_error,
    output logic signed [mftt_pkg::RAW_W-1:0]     o_speed,
    output logic signed [mftt_pkg::RAW_W-1:0]     o_current,
    output logic [mftt_pkg::TEMP_W-1:0]           o_temperature,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mftt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mftt_pkg::ID_W-1:0]             i_cfg_data
);
    import mftt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    mftt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    mftt_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_frame_id        (i_frame_id),
        .i_encoder_raw     (i_encoder_raw),
        .i_speed_raw       (i_speed_raw),
        .i_current_raw     (i_current_raw),
        .i_temperature_raw (i_temperature_raw),
        .i_target_slot     (i_target_slot),
        .i_target_counts   (i_target_counts),
        .i_target_turns    (i_target_turns),
        .o_slot            (o_slot),
        .o_angle_counts    (o_angle_counts),
        .o_turn_count      (o_turn_count),
        .o_angle_error     (o_angle_error),
        .o_speed           (o_speed),
        .o_current         (o_current),
        .o_temperature     (o_temperature)
    );

endmodule

>>> hw/rtl/mftt_ctrl.sv
module mftt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  mftt_pkg::t_dp_stat i_stat,
    output mftt_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import mftt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TURN = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept, load;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign load   = (r_state == S_ERR) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_stat.fb_hit) begin
                    n_state = S_TURN;
                end
            end
            S_TURN: n_state = S_ERR;
            S_ERR: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.accept   = accept;
    assign o_cmd.turn_en  = (r_state == S_TURN);
    assign o_cmd.out_load = load;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;

endmodule

>>> hw/rtl/mftt_datapath.sv
module mftt_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mftt_pkg::t_dp_cmd                     i_cmd,
    output mftt_pkg::t_dp_stat                    o_stat,
    input  logic                                  i_cfg_valid,
    input  logic [mftt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mftt_pkg::ID_W-1:0]             i_cfg_data,
    input  logic                                  i_op,
    input  logic [mftt_pkg::ID_W-1:0]             i_frame_id,
    input  logic [mftt_pkg::ANGLE_W-1:0]          i_encoder_raw,
    input  logic signed [mftt_pkg::RAW_W-1:0]     i_speed_raw,
    input  logic signed [mftt_pkg::RAW_W-1:0]     i_current_raw,
    input  logic [mftt_pkg::TEMP_W-1:0]           i_temperature_raw,
    input  logic [mftt_pkg::SLOT_W-1:0]           i_target_slot,
    input  logic [mftt_pkg::ANGLE_W-1:0]          i_target_counts,
    input  logic signed [mftt_pkg::TURN_W-1:0]    i_target_turns,
    output logic [mftt_pkg::SLOT_W-1:0]           o_slot,
    output logic [mftt_pkg::ANGLE_W-1:0]          o_angle_counts,
    output logic signed [mftt_pkg::TURN_W-1:0]    o_turn_count,
    output logic signed [mftt_pkg::ERR_W-1:0]     o_angle_error,
    output logic signed [mftt_pkg::RAW_W-1:0]     o_speed,
    output logic signed [mftt_pkg::RAW_W-1:0]     o_current,
    output logic [mftt_pkg::TEMP_W-1:0]           o_temperature
);
    import mftt_pkg::*;

    localparam int DIFF_W = ANGLE_W + 1;
    localparam int TDIFF_W = TURN_W + 1;
    localparam int MUL6_W = DIFF_W + 4;
    localparam int SUM_W = 32;
    localparam logic signed [MUL6_W-1:0] TURN_LIM = MUL6_W'(5 * COUNTS_PER_TURN);
    localparam logic signed [SUM_W-1:0] HALF_TURN = SUM_W'(COUNTS_PER_TURN / 2);
    localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(COUNTS_PER_TURN);

    // configuration
    logic [ID_W-1:0] r_base_abs, r_base_a, r_base_b;

    // slot table
    logic [ANGLE_W-1:0] r_angle_store  [MOTOR_COUNT];
    logic [TURN_W-1:0]  r_turn_store   [MOTOR_COUNT];
    logic [ANGLE_W-1:0] r_tangle_store [MOTOR_COUNT];
    logic [TURN_W-1:0]  r_tturn_store  [MOTOR_COUNT];

    // item registers
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_abs;
    logic [ANGLE_W-1:0]       r_ang;
    logic [RAW_W-1:0]         r_speed, r_cur;
    logic [TEMP_W-1:0]        r_temp;
    logic [TURN_W-1:0]        r_turn;
    logic signed [TDIFF_W-1:0] r_tdiff;
    logic signed [DIFF_W-1:0]  r_adiff;

    // ID decode, first matching range wins
    logic [ID_W:0]    id_x;
    logic             hit_abs, hit_a, hit_b, hit;
    logic [ID_W-1:0]  off_abs, off_a, off_b;
    logic [SLOT_W-1:0] dec_slot;

    assign id_x    = {1'b0, i_frame_id};
    assign hit_abs = (id_x >= {1'b0, r_base_abs})
                  && (id_x < ({1'b0, r_base_abs} + (ID_W+1)'(ABS_SLOTS)));
    assign hit_a   = (id_x >= {1'b0, r_base_a})
                  && (id_x < ({1'b0, r_base_a} + (ID_W+1)'(GROUP_SLOTS)));
    assign hit_b   = (id_x >= {1'b0, r_base_b})
                  && (id_x < ({1'b0, r_base_b} + (ID_W+1)'(GROUP_SLOTS)));
    assign off_abs = i_frame_id - r_base_abs;
    assign off_a   = i_frame_id - r_base_a;
    assign off_b   = i_frame_id - r_base_b;

    always_comb begin
        dec_slot = '0;
        hit      = 1'b1;
        if (hit_abs) begin
            dec_slot = SLOT_W'(ABS_FIRST_SLOT) + SLOT_W'(off_abs);
        end else if (hit_a) begin
            dec_slot = SLOT_W'(off_a);
        end else if (hit_b) begin
            dec_slot = SLOT_W'(GROUP_B_FIRST_SLOT) + SLOT_W'(off_b);
        end else begin
            hit = 1'b0;
        end
        if ({1'b0, dec_slot} >= (SLOT_W+1)'(MOTOR_COUNT)) begin
            hit = 1'b0;
        end
    end

    assign o_stat.fb_hit = (i_op == OP_FEEDBACK) && hit;

    // turn tracking on the registered slot
    logic [ANGLE_W-1:0]        ang_prev, tgt_ang;
    logic [TURN_W-1:0]         turn_prev, tgt_turn, turn_upd, n_turn;
    logic signed [DIFF_W-1:0]  d;
    logic signed [MUL6_W-1:0]  d_ext, d6;
    logic signed [TDIFF_W-1:0] n_tdiff;
    logic signed [DIFF_W-1:0]  n_adiff;

    assign ang_prev  = r_angle_store[r_slot];
    assign turn_prev = r_turn_store[r_slot];
    assign tgt_ang   = r_tangle_store[r_slot];
    assign tgt_turn  = r_tturn_store[r_slot];

    always_comb begin
        d     = $signed({1'b0, r_ang}) - $signed({1'b0, ang_prev});
        d_ext = MUL6_W'(d);
        d6    = (d_ext <<< 2) + (d_ext <<< 1);
        turn_upd = turn_prev;
        if (d6 < -TURN_LIM) begin
            turn_upd = turn_prev + TURN_W'(1);
        end else if (d6 > TURN_LIM) begin
            turn_upd = turn_prev - TURN_W'(1);
        end
        n_turn  = r_abs ? '0 : turn_upd;
        n_tdiff = r_abs ? '0
                : ($signed({tgt_turn[TURN_W-1], tgt_turn})
                   - $signed({n_turn[TURN_W-1], n_turn}));
        n_adiff = $signed({1'b0, tgt_ang}) - $signed({1'b0, r_ang});
    end

    // error with one turn correction
    logic signed [SUM_W-1:0] err, err_c;

    always_comb begin
        err   = (SUM_W'(r_tdiff) <<< ANGLE_W) + SUM_W'(r_adiff);
        err_c = err;
        if (err > HALF_TURN) begin
            err_c = err - FULL_TURN;
        end else if (err < -HALF_TURN) begin
            err_c = err + FULL_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_abs <= RST_BASE_ABS;
            r_base_a   <= RST_BASE_GROUP_A;
            r_base_b   <= RST_BASE_GROUP_B;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_ABS:     r_base_abs <= i_cfg_data;
                REG_BASE_GROUP_A: r_base_a   <= i_cfg_data;
                REG_BASE_GROUP_B: r_base_b   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_angle_store[i]  <= '0;
                r_turn_store[i]   <= '0;
                r_tangle_store[i] <= '0;
                r_tturn_store[i]  <= '0;
            end
        end else begin
            if (i_cmd.accept && i_op == OP_TARGET
                && {1'b0, i_target_slot} < (SLOT_W+1)'(MOTOR_COUNT)) begin
                r_tangle_store[i_target_slot] <= i_target_counts;
                r_tturn_store[i_target_slot]  <= i_target_turns;
            end
            if (i_cmd.turn_en) begin
                r_angle_store[r_slot] <= r_ang;
                r_turn_store[r_slot]  <= n_turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_slot  <= dec_slot;
            r_abs   <= hit_abs;
            r_ang   <= i_encoder_raw;
            r_speed <= i_speed_raw;
            r_cur   <= i_current_raw;
            r_temp  <= i_temperature_raw;
        end
        if (i_cmd.turn_en) begin
            r_turn  <= n_turn;
            r_tdiff <= n_tdiff;
            r_adiff <= n_adiff;
        end
        if (i_cmd.out_load) begin
            o_slot         <= r_slot;
            o_angle_counts <= r_ang;
            o_turn_count   <= r_turn;
            o_angle_error  <= err_c[ERR_W-1:0];
            o_speed        <= r_speed;
            o_current      <= r_cur;
            o_temperature  <= r_temp;
        end
    end

endmodule
